@@ src/md5sh_pkg.sv @@
package md5sh_pkg;

    typedef enum logic [1:0] {
        ST_IN,
        ST_PAD,
        ST_CMP,
        ST_OUT
    } t_state;

    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    // Round constants
    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    // Rotate amount per round
    function automatic logic [4:0] md5_shift(input logic [5:0] i);
        logic [4:0] s;
        unique case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // Message word index per round
    function automatic logic [3:0] md5_g(input logic [5:0] i);
        logic [3:0] g;
        unique case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
            2'd2: g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
            2'd3: g = 4'((i[3:0] << 3) - i[3:0]);
            default: g = 4'd0;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_f(input logic [5:0] i, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        unique case (i[5:4])
            2'd0: f = (b & c) | (~b & d);
            2'd1: f = (b & d) | (c & ~d);
            2'd2: f = b ^ c ^ d;
            2'd3: f = c ^ (b | ~d);
            default: f = 32'h0;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] w;
        w = {x, x} << s;
        return w[63:32];
    endfunction

endpackage

@@ src/md5_stream_hasher_unit.sv @@
// MD5 digest over a byte stream. Each accepted word carries at most one
// message byte; bytes are taken at one per cycle. Every 64th byte starts a
// block compression that holds the input (one prime read of the block
// memory, 64 rounds at one per cycle, one chaining add). A word
// marked last adds padding at one byte per cycle (9 to 72 bytes, with one or
// two compressions) and then gives the digest as four 32-bit words A, B, C, D,
// one per accepted output cycle; the low byte of A is the first digest byte.
// The block words sit in a 16-entry memory with registered read data.
module md5_stream_hasher_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [1:0]  o_word_index,
    output logic        o_last_word
);
    import md5sh_pkg::*;

    t_state      r_state, n_state;
    logic [31:0] r_chain [4];
    logic [31:0] n_chain [4];
    logic [31:0] r_a, r_b, r_c, r_d, n_a, n_b, n_c, n_d;
    logic [63:0] r_len, n_len, r_lensnap, n_lensnap;
    logic [5:0]  r_pos, n_pos;
    logic [31:0] r_word, n_word;
    logic        r_pad, n_pad, r_sent80, n_sent80, r_lenph, n_lenph;
    logic [6:0]  r_rnd, n_rnd;
    logic [1:0]  r_oidx, n_oidx;

    logic [31:0] r_mem [16];
    logic [31:0] r_mdata;
    logic [3:0]  raddr;
    logic        mem_we;

    logic        in_acc, put_en, wrap;
    logic [7:0]  put_val;
    logic [5:0]  rj;
    logic [31:0] rsum, rnew;
    logic [63:0] len_shift;

    assign in_acc = i_valid && !o_stall;
    assign wrap   = put_en && (r_pos == 6'd63);
    assign rj     = 6'(r_rnd - 7'd1);
    assign raddr  = md5_g(r_rnd[5:0]);
    assign len_shift = r_lensnap >> {r_pos[2:0], 3'b000};

    // Round datapath
    assign rsum = r_a + md5_f(rj, r_b, r_c, r_d) + md5_k(rj) + r_mdata;
    assign rnew = r_b + rotl32(rsum, md5_shift(rj));

    // Select the byte to put
    always_comb begin
        put_en  = 1'b0;
        put_val = i_data_byte;
        unique case (r_state)
            ST_IN: begin
                put_en = in_acc && i_has_byte;
            end
            ST_PAD: begin
                put_en = 1'b1;
                if (!r_sent80) begin
                    put_val = PAD_BYTE;
                end else if (r_lenph || r_pos == 6'd56) begin
                    put_val = len_shift[7:0];
                end else begin
                    put_val = 8'h00;
                end
            end
            default: begin
                put_en = 1'b0;
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IN: begin
                if (in_acc) begin
                    if (wrap)           n_state = ST_CMP;
                    else if (i_is_last) n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (wrap) n_state = ST_CMP;
            end
            ST_CMP: begin
                if (r_rnd == 7'd65) begin
                    if (r_lenph)    n_state = ST_OUT;
                    else if (r_pad) n_state = ST_PAD;
                    else            n_state = ST_IN;
                end
            end
            ST_OUT: begin
                if (!i_stall && r_oidx == 2'd3) n_state = ST_IN;
            end
            default: n_state = ST_IN;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_chain   = r_chain;
        n_a = r_a; n_b = r_b; n_c = r_c; n_d = r_d;
        n_len     = r_len;
        n_lensnap = r_lensnap;
        n_pos     = r_pos;
        n_word    = r_word;
        n_pad     = r_pad;
        n_sent80  = r_sent80;
        n_lenph   = r_lenph;
        n_rnd     = r_rnd;
        n_oidx    = r_oidx;
        mem_we    = 1'b0;

        // Merge byte into the word being assembled
        if (put_en) begin
            n_word = ((r_pos[1:0] == 2'd0) ? 32'h0 : r_word)
                   | (32'(put_val) << {r_pos[1:0], 3'b000});
            mem_we = (r_pos[1:0] == 2'd3);
            n_pos  = 6'(r_pos + 6'd1);
        end
        if (wrap) begin
            n_a = r_chain[0]; n_b = r_chain[1];
            n_c = r_chain[2]; n_d = r_chain[3];
            n_rnd = 7'd0;
        end

        unique case (r_state)
            ST_IN: begin
                if (in_acc) begin
                    if (i_has_byte) n_len = r_len + 64'd8;
                    if (i_is_last) begin
                        n_pad     = 1'b1;
                        n_sent80  = 1'b0;
                        n_lenph   = 1'b0;
                        n_lensnap = i_has_byte ? (r_len + 64'd8) : r_len;
                    end
                end
            end
            ST_PAD: begin
                if (!r_sent80) n_sent80 = 1'b1;
                else if (r_lenph || r_pos == 6'd56) n_lenph = 1'b1;
            end
            ST_CMP: begin
                n_rnd = 7'(r_rnd + 7'd1);
                if (r_rnd != 7'd0 && r_rnd <= 7'd64) begin
                    n_a = r_d; n_d = r_c; n_c = r_b; n_b = rnew;
                end
                if (r_rnd == 7'd65) begin
                    n_chain[0] = r_chain[0] + r_a;
                    n_chain[1] = r_chain[1] + r_b;
                    n_chain[2] = r_chain[2] + r_c;
                    n_chain[3] = r_chain[3] + r_d;
                    n_oidx     = 2'd0;
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    n_oidx = 2'(r_oidx + 2'd1);
                    if (r_oidx == 2'd3) begin
                        n_chain[0] = INIT_A; n_chain[1] = INIT_B;
                        n_chain[2] = INIT_C; n_chain[3] = INIT_D;
                        n_len   = 64'd0;
                        n_pad   = 1'b0;
                        n_sent80 = 1'b0;
                        n_lenph = 1'b0;
                    end
                end
            end
            default: begin
                n_rnd = r_rnd;
            end
        endcase
    end

    // Hold control and chaining state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IN;
            r_chain[0] <= INIT_A; r_chain[1] <= INIT_B;
            r_chain[2] <= INIT_C; r_chain[3] <= INIT_D;
            r_len    <= 64'd0;
            r_pos    <= 6'd0;
            r_pad    <= 1'b0;
            r_sent80 <= 1'b0;
            r_lenph  <= 1'b0;
            r_rnd    <= 7'd0;
            r_oidx   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_chain  <= n_chain;
            r_len    <= n_len;
            r_pos    <= n_pos;
            r_pad    <= n_pad;
            r_sent80 <= n_sent80;
            r_lenph  <= n_lenph;
            r_rnd    <= n_rnd;
            r_oidx   <= n_oidx;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_a <= n_a; r_b <= n_b; r_c <= n_c; r_d <= n_d;
        r_word    <= n_word;
        r_lensnap <= n_lensnap;
    end

    // Block word memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pos[5:2]] <= n_word;
        end
        r_mdata <= r_mem[raddr];
    end

    // Drive ports
    always_comb begin
        o_stall       = (r_state != ST_IN);
        o_valid       = (r_state == ST_OUT);
        o_digest_word = r_chain[r_oidx];
        o_word_index  = r_oidx;
        o_last_word   = (r_oidx == 2'd3);
    end

    // Checks
    a_cmp_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_pos == 6'd0))
        else $error("compression with partial block");
    a_no_put_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP || r_state == ST_OUT) |-> !mem_we)
        else $error("block write during compression or output");
    a_out_after_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_lenph && r_pad))
        else $error("digest without length field");
    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> (r_rnd <= 7'd65))
        else $error("round counter overrun");
endmodule

@@ verif/md5_digest_checker.sv @@
`timescale 1ns / 1ps

module md5_digest_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_is_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_digest_word,
    input  logic [1:0]  i_word_index,
    input  logic        i_last_word,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_digest_count
);
    import md5sh_pkg::*;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_digest_word;

    localparam logic [31:0] ADD_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                   4, 11, 16, 23, 6, 10, 15, 21};

    logic [31:0]  chain [4];
    logic [31:0]  msg_block [16];
    logic [63:0]  msg_bits;
    logic [5:0]   fill_pos;
    t_digest_word digest_q [$];
    int           fails;

    assign o_fail_count   = fails;
    assign o_pending      = digest_q.size();

    function automatic logic [31:0] rot_left(logic [31:0] x, int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    // Run the 64 rounds over the buffered block and fold into the chain
    task automatic compress();
        logic [31:0] a, b, c, d, f, t;
        int g;
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = d; d = c; c = b;
            b = b + rot_left(a + f + ADD_K[i] + msg_block[g], ROT_AMT[(i / 16) * 4 + i % 4]);
            a = t;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic absorb_byte(logic [7:0] v);
        if (fill_pos[1:0] == 2'd0) msg_block[fill_pos[5:2]] = '0;
        msg_block[fill_pos[5:2]][fill_pos[1:0] * 8 +: 8] = v;
        fill_pos++;
        if (fill_pos == 6'd0) compress();
    endtask

    task automatic restart_message();
        chain = '{INIT_A, INIT_B, INIT_C, INIT_D};
        msg_bits = '0;
        fill_pos = '0;
    endtask

    // Predict on each accepted input word
    always @(posedge i_clk) begin
        logic [63:0] len;
        if (!i_rst_n) begin
            restart_message();
            digest_q.delete();
            fails = 0;
            o_digest_count = 0;
        end else begin
            if (i_valid && !i_stall_in) begin
                if (i_has_byte) begin
                    absorb_byte(i_data_byte);
                    msg_bits += 64'd8;
                end
                if (i_is_last) begin
                    len = msg_bits;
                    absorb_byte(PAD_BYTE);
                    while (fill_pos != 6'd56) absorb_byte(8'h00);
                    for (int k = 0; k < 8; k++) absorb_byte(len[8 * k +: 8]);
                    for (int k = 0; k < 4; k++)
                        digest_q.push_back('{chain[k], 2'(k), k == 3});
                    restart_message();
                end
            end
            // Compare each accepted digest word with the oldest prediction
            if (i_out_valid && !i_out_stall) begin
                t_digest_word exp_w;
                o_digest_count++;
                if (digest_q.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("ERROR: unexpected digest word %h idx %0d last %0b",
                                 i_digest_word, i_word_index, i_last_word);
                end else begin
                    exp_w = digest_q.pop_front();
                    if (exp_w.digest_word !== i_digest_word
                        || exp_w.word_index !== i_word_index
                        || exp_w.last_word !== i_last_word) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: expected %h/%0d/%0b got %h/%0d/%0b",
                                     exp_w.digest_word, exp_w.word_index,
                                     exp_w.last_word, i_digest_word, i_word_index,
                                     i_last_word);
                    end
                end
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        has_byte = 1'b0;
    logic        is_last = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
    int          fail_count;
    int          pending;
    int          digest_count;

    // Stall control: burst idling, a long hold-off window, quiet tail
    bit          calm = 1'b0;
    bit          long_hold = 1'b0;
    int          messages = 0;
    int          words_sent = 0;

    always #1 i_clk = ~i_clk;

    md5_stream_hasher_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_is_last(is_last),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_digest_word(digest_word), .o_word_index(word_index),
        .o_last_word(last_word)
    );

    md5_digest_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(in_valid), .i_stall_in(in_stall),
        .i_data_byte(data_byte), .i_has_byte(has_byte), .i_is_last(is_last),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_digest_word(digest_word), .i_word_index(word_index),
        .i_last_word(last_word),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_digest_count(digest_count)
    );

    // Drive one word and hold it until accepted, with random gaps before
    task automatic send_word(logic [7:0] b, logic hb, logic lst);
        if (!calm && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        has_byte  <= hb;
        is_last   <= lst;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        words_sent++;
        if (lst) messages++;
    endtask

    task automatic send_message(int n_bytes, bit empty_last, bit fill_ff);
        for (int i = 0; i < n_bytes - (empty_last ? 0 : 1); i++)
            send_word(fill_ff ? 8'hff : 8'($urandom), 1'b1, 1'b0);
        if (empty_last || n_bytes == 0) send_word(8'($urandom), 1'b0, 1'b1);
        else send_word(fill_ff ? 8'hff : 8'($urandom), 1'b1, 1'b1);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Receiver stall process
    initial begin
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                out_stall <= 1'b0;
            end
            @(posedge i_clk);
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty message, zero and all-ones bytes, padding edges
        send_message(0, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'hff, 1'b0, 1'b0);
        send_message(1, 1'b0, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h55, 1'b0, 1'b0);
        send_word(8'haa, 1'b1, 1'b1);
        send_message(3, 1'b1, 1'b0);
        drain();

        // Hold off the receiver while further messages wait at the stalled input
        long_hold = 1'b1;
        for (int m = 0; m < 4; m++) send_message($urandom_range(0, 4), $urandom_range(0, 1), 0);
        drain();
        while (long_hold) @(posedge i_clk);

        // Block boundaries: 55, 56, 63, 64 bytes
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b0, 1'b1);
        send_message(63, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        drain();

        // Random messages, with idle words mixed in
        while (words_sent < 330) begin
            if ($urandom_range(0, 9) == 0)
                send_word(8'($urandom), 1'b0, 1'b0);
            else
                send_message($urandom_range(0, 9) == 0 ? $urandom_range(50, 70)
                             : $urandom_range(0, 20), $urandom_range(0, 3) == 0, 0);
            if (words_sent > 290) calm = 1'b1;
        end
        in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Hashed %0d messages from %0d input words, checked %0d digest words.",
                 messages, words_sent, digest_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
